FILE: design/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants of the serial line editor
// Item kinds, result sources, control characters, line capacity and the
// response record passed from the line editor to the result stage.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int LINE_CAPACITY = 32;
    localparam int FILL_W        = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
    localparam int KIND_W        = 2;
    localparam int SRC_W         = 2;
    localparam int BYTE_W        = 8;
    localparam int IDX_W         = 5;
    // wide enough to compare any read index against the capacity
    localparam int IDXX_W        = FILL_W + IDX_W;

    localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
    localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

    typedef enum logic [KIND_W-1:0] {
        KIND_RX      = 2'd0,
        KIND_READ    = 2'd1,
        KIND_RELEASE = 2'd2
    } kind_t;

    typedef enum logic [SRC_W-1:0] {
        SRC_ECHO    = 2'd0,
        SRC_READ    = 2'd1,
        SRC_RELEASE = 2'd2
    } src_t;

    // position within the backspace echo burst (BS, SP, BS)
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_MIDDLE = 2'd1,
        PH_LAST   = 2'd2
    } phase_t;

    typedef struct packed {
        logic              has_result;
        logic              bs_burst;
        src_t              source;
        logic [BYTE_W-1:0] data;
        logic              line_ready;
    } resp_t;

endpackage

FILE: design/sle_edit.sv
// ----------------------------------------------------------------------------
// sle_edit: line store, fill position and ready flag
// Decodes one registered item, updates the editor state when told to apply
// it and describes the results the item produces.
// ----------------------------------------------------------------------------
module sle_edit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        apply,
    input  logic [sle_pkg::KIND_W-1:0]  kind,
    input  logic [sle_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [sle_pkg::IDX_W-1:0]   read_index,
    output sle_pkg::resp_t              resp
);
    import sle_pkg::*;

    logic [BYTE_W-1:0] store_reg [LINE_CAPACITY];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              flag_reg;
    logic              flag_next;
    logic              wr_en;
    logic [BYTE_W-1:0] wr_data;
    logic [IDXX_W-1:0] idx_ext;

    assign idx_ext = IDXX_W'(read_index);

    always_comb
    begin
        resp            = '0;
        resp.source     = SRC_ECHO;
        resp.line_ready = flag_reg;
        fill_next       = fill_reg;
        flag_next       = flag_reg;
        wr_en           = 1'b0;
        wr_data         = rx_byte;
        unique case (kind_t'(kind))
            KIND_RX:
            begin
                if (!flag_reg)
                begin
                    resp.has_result = 1'b1;
                    priority if (rx_byte == CH_BS && fill_reg != '0)
                    begin
                        // erase: step back, echo BS SP BS
                        fill_next     = fill_reg - FILL_W'(1);
                        resp.bs_burst = 1'b1;
                        resp.data     = CH_BS;
                    end
                    else if (rx_byte != CH_CR && rx_byte != CH_LF &&
                             fill_reg != FILL_W'(LINE_CAPACITY - 1))
                    begin
                        wr_en     = 1'b1;
                        fill_next = fill_reg + FILL_W'(1);
                        resp.data = rx_byte;
                    end
                    else
                    begin
                        // end of line (CR, LF or a full store): terminate, raise flag, echo CR
                        wr_en           = 1'b1;
                        wr_data         = CH_NUL;
                        fill_next       = '0;
                        flag_next       = 1'b1;
                        resp.data       = CH_CR;
                        resp.line_ready = 1'b1;
                    end
                end
            end
            KIND_READ:
            begin
                resp.has_result = 1'b1;
                resp.source     = SRC_READ;
                if (idx_ext < IDXX_W'(LINE_CAPACITY))
                    resp.data = store_reg[idx_ext[FILL_W-1:0]];
                else
                    resp.data = CH_NUL;
            end
            KIND_RELEASE:
            begin
                resp.has_result = 1'b1;
                resp.source     = SRC_RELEASE;
                resp.data       = CH_NUL;
                resp.line_ready = 1'b0;
                flag_next       = 1'b0;
            end
            default:
            begin
                resp.has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            flag_reg <= 1'b0;
            for (int i = 0; i < LINE_CAPACITY; i++)
                store_reg[i] <= '0;
        end
        else if (apply)
        begin
            fill_reg <= fill_next;
            flag_reg <= flag_next;
            if (wr_en)
                store_reg[fill_reg] <= wr_data;
        end
    end

endmodule

FILE: design/serial_line_editor_echo_core.sv
// ----------------------------------------------------------------------------
// serial_line_editor_echo_core: serial line editor with echo
// Collects received bytes into a line store, returns echo bytes, serves
// reads of the stored line and releases a completed line.
// ----------------------------------------------------------------------------
// An accepted item waits in the input register until the output register can
// take its results; the editor then applies it, and its first result shows
// on the output in the next cycle. The output register sends one result per
// cycle while out_stall is low: an ordinary byte, CR, read or release gives
// one result, a backspace that erases gives three (BS, SP, BS) and holds the
// output register until the last is sent. Items without results (bytes
// received while a completed line waits, and the unused kind) are applied
// without waiting for the output. With no output stall, single-result items
// flow at one per cycle; the three-result echo burst is the rate limiter. The
// line store is flip-flops cleared by reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module serial_line_editor_echo_core (
    input  logic                        clk,
    input  logic                        rst_n,
    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [sle_pkg::KIND_W-1:0]  kind,
    input  logic [sle_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [sle_pkg::IDX_W-1:0]   read_index,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [sle_pkg::SRC_W-1:0]   source,
    output logic [sle_pkg::BYTE_W-1:0]  out_byte,
    output logic                        line_ready,
    output logic                        last
);
    import sle_pkg::*;

    // input register
    logic              in_vld_reg;
    logic              in_vld_next;
    logic [KIND_W-1:0] kind_reg;
    logic [BYTE_W-1:0] rx_reg;
    logic [IDX_W-1:0]  idx_reg;

    // result register
    logic              out_vld_reg;
    logic              out_vld_next;
    src_t              src_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              rdy_reg;
    logic              bs_reg;
    phase_t            phase_reg;
    phase_t            phase_next;

    resp_t             resp;
    logic              in_xfer;
    logic              out_xfer;
    logic              out_last;
    logic              slot_free;
    logic              advance;
    logic              load_out;

    sle_edit u_edit (
        .clk        (clk),
        .rst_n      (rst_n),
        .apply      (advance),
        .kind       (kind_reg),
        .rx_byte    (rx_reg),
        .read_index (idx_reg),
        .resp       (resp)
    );

    // the output slot frees up on the transfer of the final result of a burst
    assign out_last  = !bs_reg || (phase_reg == PH_LAST);
    assign out_xfer  = out_vld_reg && !out_stall;
    assign slot_free = !out_vld_reg || (out_xfer && out_last);

    // apply the held item once its results have somewhere to go
    assign advance  = in_vld_reg && (!resp.has_result || slot_free);
    assign load_out = advance && resp.has_result;
    assign in_stall = in_vld_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_xfer)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        phase_next   = phase_reg;
        priority if (load_out)
        begin
            out_vld_next = 1'b1;
            phase_next   = PH_FIRST;
        end
        else if (out_xfer)
        begin
            if (out_last)
                out_vld_next = 1'b0;
            else
                phase_next = (phase_reg == PH_FIRST) ? PH_MIDDLE : PH_LAST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            phase_reg   <= PH_FIRST;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            phase_reg   <= phase_next;
        end
    end

    // hold the payload of the accepted item
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            kind_reg <= kind;
            rx_reg   <= rx_byte;
            idx_reg  <= read_index;
        end
    end

    // capture the result description of the applied item
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            src_reg  <= resp.source;
            byte_reg <= resp.data;
            rdy_reg  <= resp.line_ready;
            bs_reg   <= resp.bs_burst;
        end
    end

    assign out_valid  = out_vld_reg;
    assign source     = src_reg;
    // the middle of the erase burst is a space
    assign out_byte   = (bs_reg && phase_reg == PH_MIDDLE) ? CH_SP : byte_reg;
    assign line_ready = rdy_reg;
    assign last       = out_last;

endmodule

FILE: design/sle_checker.sv
// ----------------------------------------------------------------------------
// sle_checker: port-level checks of the serial line editor
// Watches the top-level ports and flags result sequences the editor
// never produces; bound to the top level below.
// ----------------------------------------------------------------------------
module sle_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [sle_pkg::SRC_W-1:0]   source,
    input logic [sle_pkg::BYTE_W-1:0]  out_byte,
    input logic                        line_ready,
    input logic                        last
);
    import sle_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_byte) && $stable(source)))
        else $error("stalled result changed");

    // input backs up only behind a pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // only an echo burst has results before its final one
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (source == SRC_ECHO))
        else $error("multi-result item that is not an echo");

    // a release always leaves the line flag clear
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && source == SRC_RELEASE) |-> (!line_ready && out_byte == CH_NUL))
        else $error("release acknowledgement malformed");

endmodule

bind serial_line_editor_echo_core sle_checker u_sle_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .source     (source),
    .out_byte   (out_byte),
    .line_ready (line_ready),
    .last       (last)
);
